// File: sv/ntt_pkg.sv
// shared types, constants and digit helpers for the nixie time and temperature frame encoder
// no dependencies; imported by every module of the block

package ntt_pkg;

  // field widths
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int TEMP_W    = 16;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 8;
  localparam int M_TUSER_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_AFTER  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_BEFORE = 1'd1;

  localparam logic [CFG_W-1:0] BLANK_AFTER_RESET  = 5'd1;
  localparam logic [CFG_W-1:0] BLANK_BEFORE_RESET = 5'd6;

  // temperature range handling
  localparam logic [TEMP_W-1:0] MAG_LIMIT = 16'd1000;
  // floor(x * 52429 / 2^19) equals floor(x / 10) for every x up to 43689
  localparam logic [TEMP_W-1:0] DIV10_MUL   = 16'd52429;
  localparam int                DIV10_SHIFT = 19;
  localparam int                MAG1_W      = 12;

  localparam logic [7:0] BLANK_BYTE = 8'hFF;

  // byte slots in a frame
  localparam logic [1:0] POS_HOUR      = 2'd0;
  localparam logic [1:0] POS_MINUTE    = 2'd1;
  localparam logic [1:0] POS_TEMP_LOW  = 2'd2;
  localparam logic [1:0] POS_TEMP_HIGH = 2'd3;

  // one classified item, as it waits between front and back
  typedef struct packed {
    logic                blank;
    logic                point;
    logic                ovf;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [3:0]          hund;
    logic [3:0]          tens;
    logic [3:0]          units;
  } item_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } dig2_t;

  // split a value below 100 into tens and ones
  function automatic dig2_t split_99(input logic [6:0] v);
    dig2_t      r;
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 7'(k * 10)) t = 4'(k);
    end
    r.tens = t;
    r.ones = 4'(v - 7'(t) * 7'd10);
    return r;
  endfunction

  // digit to tube-driver code, time tubes
  function automatic logic [3:0] time_code(input logic [3:0] d);
    logic [3:0] c;
    unique case (d)
      4'd0: c = 4'd4;
      4'd1: c = 4'd5;
      4'd2: c = 4'd1;
      4'd3: c = 4'd0;
      4'd4: c = 4'd9;
      4'd5: c = 4'd8;
      4'd6: c = 4'd2;
      4'd7: c = 4'd3;
      4'd8: c = 4'd7;
      4'd9: c = 4'd6;
      default: c = 4'hF;
    endcase
    return c;
  endfunction

  // digit to tube-driver code, temperature tubes
  function automatic logic [3:0] temp_code(input logic [3:0] d);
    logic [3:0] c;
    unique case (d)
      4'd0: c = 4'd5;
      4'd1: c = 4'd6;
      4'd2: c = 4'd7;
      4'd3: c = 4'd3;
      4'd4: c = 4'd2;
      4'd5: c = 4'd4;
      4'd6: c = 4'd1;
      4'd7: c = 4'd8;
      4'd8: c = 4'd9;
      4'd9: c = 4'd0;
      default: c = 4'hF;
    endcase
    return c;
  endfunction

  // ones slot: code bits 1,2,4,8 land on nibble bits 3,1,0,2
  function automatic logic [3:0] ones_nibble(input logic [3:0] c);
    return {c[0], c[3], c[1], c[2]};
  endfunction

  // time tens slot: code bits 1,2,4,8 land on byte bits 7,5,4,6
  function automatic logic [3:0] time_tens_nibble(input logic [3:0] c);
    return {c[0], c[3], c[1], c[2]};
  endfunction

  // temperature tens slot: code bits 1,2,4,8 land on byte bits 4,6,7,5
  function automatic logic [3:0] temp_tens_nibble(input logic [3:0] c);
    return {c[2], c[1], c[3], c[0]};
  endfunction

  function automatic logic [7:0] time_byte(input logic [6:0] v);
    dig2_t d;
    d = split_99(v);
    return {time_tens_nibble(time_code(d.tens)), ones_nibble(time_code(d.ones))};
  endfunction

  function automatic logic [7:0] temp_byte(input logic [3:0] tens, input logic [3:0] ones);
    return {temp_tens_nibble(temp_code(tens)), ones_nibble(temp_code(ones))};
  endfunction

endpackage

// File: sv/ntt_front.sv
// front end: accepts input words, checks blanking, scales the temperature and splits digits
// depends on ntt_pkg; pushes classified items into ntt_queue

module ntt_front #(
  parameter int QUEUE_DEPTH = 4,
  parameter int CW          = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // hour [4:0], minute [10:5], temperature [26:11], zero fill [31:27]
  input  logic [ntt_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic [ntt_pkg::CFG_W-1:0]     blank_after,
  input  logic [ntt_pkg::CFG_W-1:0]     blank_before,
  input  logic [CW-1:0]                 q_count,
  output logic                          push,
  output ntt_pkg::item_t                push_item
);
  import ntt_pkg::*;

  logic                  accept;
  logic [HOUR_W-1:0]     in_hour;
  logic [MINUTE_W-1:0]   in_minute;
  logic [TEMP_W-1:0]     in_temp;
  logic [1:0]            inflight;
  logic [CW:0]           occupancy;

  // stage a: captured word
  logic                  a_valid;
  logic                  a_blank;
  logic [HOUR_W-1:0]     a_hour;
  logic [MINUTE_W-1:0]   a_minute;
  logic [TEMP_W-1:0]     a_mag;

  // stage b: scaled magnitude
  logic                  b_valid;
  logic                  b_blank;
  logic                  b_point;
  logic [HOUR_W-1:0]     b_hour;
  logic [MINUTE_W-1:0]   b_minute;
  logic [MAG1_W-1:0]     b_mag;
  logic [2*TEMP_W-1:0]   prod;

  // stage c: digits
  logic                  c_valid;
  item_t                 c_item;
  logic [3:0]            hund;
  logic [6:0]            rem;
  dig2_t                 low;

  assign in_hour   = s_axis_tdata[HOUR_W-1:0];
  assign in_minute = s_axis_tdata[HOUR_W+MINUTE_W-1:HOUR_W];
  assign in_temp   = s_axis_tdata[HOUR_W+MINUTE_W+TEMP_W-1:HOUR_W+MINUTE_W];

  // credit check: every word in the pipe has a queue slot waiting for it
  assign inflight  = 2'({1'b0, a_valid} + {1'b0, b_valid} + {1'b0, c_valid});
  assign occupancy = (CW+1)'(q_count) + (CW+1)'(inflight);
  assign s_axis_tready = (occupancy < (CW+1)'(QUEUE_DEPTH));
  assign accept = s_axis_tvalid && s_axis_tready;

  // stage a: blanking window and magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
    a_blank  <= (in_hour > blank_after) && (in_hour < blank_before);
    a_hour   <= in_hour;
    a_minute <= in_minute;
    a_mag    <= in_temp[TEMP_W-1] ? TEMP_W'(~in_temp + 1'b1) : in_temp;
  end

  // stage b: divide by ten when the magnitude reaches four digits
  assign prod = (2*TEMP_W)'(a_mag) * (2*TEMP_W)'(DIV10_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_blank  <= a_blank;
    b_hour   <= a_hour;
    b_minute <= a_minute;
    if (a_mag >= MAG_LIMIT) begin
      b_mag   <= prod[DIV10_SHIFT+MAG1_W-1:DIV10_SHIFT];
      b_point <= 1'b0;
    end else begin
      b_mag   <= a_mag[MAG1_W-1:0];
      b_point <= !a_blank;
    end
  end

  // stage c: hundreds by threshold count, then tens and units
  always_comb begin
    hund = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (b_mag >= MAG1_W'(k * 100)) hund = 4'(k);
    end
    rem = 7'(b_mag - MAG1_W'(hund) * MAG1_W'(100));
    low = split_99(rem);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_item.blank  <= b_blank;
    c_item.point  <= b_point;
    c_item.ovf    <= (b_mag >= MAG1_W'(MAG_LIMIT));
    c_item.hour   <= b_hour;
    c_item.minute <= b_minute;
    c_item.hund   <= hund;
    c_item.tens   <= low.tens;
    c_item.units  <= low.ones;
  end

  assign push      = c_valid;
  assign push_item = c_item;

endmodule

// File: sv/ntt_queue.sv
// short queue of classified items between front and back
// depends on ntt_pkg for the item type

module ntt_queue #(
  parameter int QUEUE_DEPTH = 4,
  parameter int AW          = 2,
  parameter int CW          = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ntt_pkg::item_t push_item,
  input  logic           pop,
  output ntt_pkg::item_t head,
  output logic           empty,
  output logic [CW-1:0]  count
);
  import ntt_pkg::*;

  item_t         mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);

endmodule

// File: sv/ntt_back.sv
// back end: walks the four frame bytes of the head item into the output register
// depends on ntt_pkg for the item type and byte encoders

module ntt_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ntt_pkg::item_t                head,
  input  logic                          q_empty,
  output logic                          pop,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // frame_byte [7:0]
  output logic [ntt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // byte_position [1:0], decimal_point [2]
  output logic [ntt_pkg::M_TUSER_W-1:0] m_axis_tuser,
  output logic                          m_axis_tlast
);
  import ntt_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic [7:0] byte_val;

  assign load = !q_empty && (!m_axis_tvalid || m_axis_tready);
  assign pop  = load && (idx == POS_TEMP_HIGH);

  // select the byte for the current slot
  always_comb begin
    unique case (idx)
      POS_HOUR:      byte_val = time_byte(7'(head.hour));
      POS_MINUTE:    byte_val = time_byte(7'(head.minute));
      POS_TEMP_LOW:  byte_val = head.ovf ? BLANK_BYTE : temp_byte(4'd0, head.units);
      POS_TEMP_HIGH: byte_val = head.ovf ? BLANK_BYTE : temp_byte(head.hund, head.tens);
      default:       byte_val = BLANK_BYTE;
    endcase
    if (head.blank) byte_val = BLANK_BYTE;
  end

  // slot counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      idx           <= POS_HOUR;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load) begin
        idx           <= 2'(idx + 1'b1);
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (load) begin
      m_axis_tdata <= byte_val;
      m_axis_tuser <= {head.point, idx};
      m_axis_tlast <= (idx == POS_TEMP_HIGH);
    end
  end

endmodule

// File: sv/nixie_time_temp_frame_encoder.sv
// top level of the nixie time and temperature frame encoder: config registers and wiring
// depends on ntt_pkg, ntt_front, ntt_queue, ntt_back
//
//   channel  | dir | handshake               | payload
//   s_axis   | in  | s_axis_tvalid/tready    | tdata: hour, minute, temperature
//   m_axis   | out | m_axis_tvalid/tready    | tdata: frame_byte; tuser: position, point;
//            |     |                         | tlast: last_byte
//   cfg      | in  | cfg_we                  | cfg_index, cfg_data
//
// each input word gives four output words, one per cycle while m_axis_tready is high;
// the byte sequencer moves to the next queued item only after loading its last byte.
// the first byte is registered through stage a, stages b and c, the queue write and
// the output register before it is valid.
// s_axis_tready drops once words in the front pipe plus queued items reach QUEUE_DEPTH.
// reset clears all valid flags and loads blank_after_hour = 1, blank_before_hour = 6.
// QUEUE_DEPTH must be 2 or more (unchecked); 4 keeps the input side from stalling on a steady stream.

module nixie_time_temp_frame_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // hour [4:0], minute [10:5], temperature [26:11], zero fill [31:27]
  input  logic [ntt_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // frame_byte [7:0]
  output logic [ntt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // byte_position [1:0], decimal_point [2]
  output logic [ntt_pkg::M_TUSER_W-1:0] m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          cfg_we,
  input  logic [ntt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ntt_pkg::CFG_W-1:0]     cfg_data
);
  import ntt_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CFG_W-1:0] blank_after;
  logic [CFG_W-1:0] blank_before;
  logic             push;
  item_t            push_item;
  logic             pop;
  item_t            head;
  logic             q_empty;
  logic [CW-1:0]    q_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blank_after  <= BLANK_AFTER_RESET;
      blank_before <= BLANK_BEFORE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLANK_AFTER:  blank_after  <= cfg_data;
        REG_BLANK_BEFORE: blank_before <= cfg_data;
        default: ;
      endcase
    end
  end

  ntt_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CW          (CW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .blank_after   (blank_after),
    .blank_before  (blank_before),
    .q_count       (q_count),
    .push          (push),
    .push_item     (push_item)
  );

  ntt_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .count     (q_count)
  );

  ntt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
